// ===== hw/rtl/arrt_pkg.sv =====
// Shared types, constants and codes for the address range reservation table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package arrt_pkg;

    localparam int PW     = 19;   // page number width
    localparam int LW     = 20;   // page count width
    localparam int CW     = 11;   // protection code width
    localparam int GW     = 9;    // granule width
    localparam int DW     = 21;   // internal page arithmetic width
    localparam int CFG_AW = 2;    // config register index width

    localparam int MAX_RANGES_DEF = 64;

    localparam logic [LW-1:0] PAGE_LIMIT  = 20'd524288;
    localparam logic [PW-1:0] LOWEST_RST  = 19'd16;
    localparam logic [LW-1:0] HIGHEST_RST = 20'd524256;
    localparam logic [GW-1:0] GRANULE_RST = 9'd16;

    // remainder unit: quotient bits retired per cycle
    localparam int REM_BITS   = 4;
    localparam int REM_CYCLES = (DW + REM_BITS - 1) / REM_BITS;
    localparam int REM_XW     = REM_CYCLES * REM_BITS;

    typedef enum logic [1:0] {
        MODE_ANY = 2'd0,
        MODE_AT  = 2'd1,
        MODE_REL = 2'd2,
        MODE_QRY = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_SPACE     = 3'd1,
        ST_INVALID      = 3'd2,
        ST_CONFLICT     = 3'd3,
        ST_TABLE_FULL   = 3'd4,
        ST_NOT_RESERVED = 3'd5,
        ST_NOT_AT_BASE  = 3'd6,
        ST_BEYOND       = 3'd7
    } t_status;

    typedef enum logic [CFG_AW-1:0] {
        CFG_LOWEST  = 2'd0,
        CFG_HIGHEST = 2'd1,
        CFG_GRANULE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_mode           mode;
        logic [PW-1:0]   address_page;
        logic [LW-1:0]   size_pages;
        logic            top_down;
        logic [CW-1:0]   protect_code;
    } t_req;

    typedef struct packed {
        t_status         status;
        logic [PW-1:0]   base_page;
        logic [LW-1:0]   length_pages;
        logic            is_reserved;
        logic [CW-1:0]   range_protect;
        logic [LW-1:0]   reserved_total;
    } t_rsp;

    typedef struct packed {
        logic [PW-1:0]   base;
        logic [LW-1:0]   len;
        logic [CW-1:0]   prot;
    } t_entry;

    // effective window and granule
    typedef struct packed {
        logic [PW-1:0]   lo;
        logic [LW-1:0]   hi;
        logic [GW-1:0]   g;
    } t_cfg;

    typedef struct packed {
        logic            start;
        logic [DW-1:0]   x;
    } t_rem_req;

    typedef struct packed {
        logic            done;
        logic [DW-1:0]   down;
    } t_rem_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_REM_WAIT,
        S_RD,
        S_EV,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        PH_GAP_UP,
        PH_GAP_DN,
        PH_AT,
        PH_FIND,
        PH_POS
    } t_phase;

    typedef enum logic [1:0] {
        RR_UP,
        RR_DN_INIT,
        RR_DN,
        RR_AT
    } t_rret;

    typedef enum logic [4:0] {
        ACT_WAIT,
        ACT_ACCEPT,
        ACT_FAIL,
        ACT_SCAN,
        ACT_REM,
        ACT_REM_DONE,
        ACT_READ,
        ACT_STEP,
        ACT_PLACE,
        ACT_POS_FOUND,
        ACT_QRY_FREE,
        ACT_QRY_HIT,
        ACT_REL_WHOLE,
        ACT_REL_EDGE,
        ACT_REL_MID,
        ACT_UP_READ,
        ACT_UP_WRITE,
        ACT_UP_LAST,
        ACT_DN_READ,
        ACT_DN_WRITE,
        ACT_DN_LAST,
        ACT_FINISH
    } t_act;

endpackage

// ===== hw/rtl/arrt_rem.sv =====
// Iterative round-down unit: returns x - (x mod g), REM_BITS quotient bits per cycle.
// Depends on arrt_pkg.
`timescale 1ns / 1ps

module arrt_rem import arrt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_rem_req           i_req,
    input  logic [GW-1:0]      i_g,
    output t_rem_rsp           o_rsp
);

    localparam int CNTW = $clog2(REM_CYCLES + 1);

    logic [REM_XW-1:0] r_x,    n_x;
    logic [DW-1:0]     r_orig;
    logic [GW-1:0]     r_g;
    logic [GW-1:0]     r_rem,  n_rem;
    logic [CNTW-1:0]   r_cnt;
    logic              r_busy;
    logic              r_done;

    // restoring remainder steps over the top bits of the shifter
    always_comb begin
        logic [GW:0]   v;
        logic [GW-1:0] t;
        t = r_rem;
        for (int k = 0; k < REM_BITS; k++) begin
            v = {t, r_x[REM_XW-1-k]};
            if (v >= {1'b0, r_g}) begin
                t = GW'(v - {1'b0, r_g});
            end else begin
                t = v[GW-1:0];
            end
        end
        n_rem = t;
        n_x   = r_x << REM_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(REM_CYCLES);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x    <= REM_XW'(i_req.x);
            r_orig <= i_req.x;
            r_g    <= i_g;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_x   <= n_x;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.down = r_orig - DW'(r_rem);

endmodule

// ===== hw/rtl/arrt_mem.sv =====
// Range table storage: one write port, one read port with registered data.
// Depends on arrt_pkg for the entry type.
`timescale 1ns / 1ps

module arrt_mem import arrt_pkg::*; #(
    parameter int DEPTH = MAX_RANGES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/arrt_seq.sv =====
// Request sequencer: scans the sorted table, drives the round-down unit, and
// shifts entries to insert or remove. Depends on arrt_pkg.
`timescale 1ns / 1ps

module arrt_seq import arrt_pkg::*; #(
    parameter int MAX_RANGES = MAX_RANGES_DEF,
    parameter int AW         = $clog2(MAX_RANGES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_req          i_cmd,
    input  t_cfg          i_cfg,
    output logic          o_busy,
    output logic          o_valid,
    output t_rsp          o_result,
    output t_rem_req      o_rem,
    input  t_rem_rsp      i_rem,
    output logic          o_mem_we,
    output logic [AW-1:0] o_mem_waddr,
    output t_entry        o_mem_wdata,
    output logic [AW-1:0] o_mem_raddr,
    input  t_entry        i_mem_rdata
);

    localparam int IW = $clog2(MAX_RANGES + 1);

    t_state          r_state, n_state;
    t_phase          r_ph,    n_ph;
    t_rret           r_rr,    n_rr;
    t_mode           r_mode,  n_mode;
    logic [PW-1:0]   r_addr,  n_addr;
    logic [LW-1:0]   r_size,  n_size;
    logic            r_top,   n_top;
    logic [IW-1:0]   r_cnt,   n_cnt;
    logic [IW-1:0]   r_idx,   n_idx;
    logic [IW-1:0]   r_pos,   n_pos;
    logic [DW-1:0]   r_cur,   n_cur;
    logic [DW-1:0]   r_end,   n_end;
    t_entry          r_new,   n_new;
    logic [LW-1:0]   r_total, n_total;
    t_rsp            r_res,   n_res;

    t_act            act;
    t_status         fcode;

    logic [DW-1:0]   lo21, hi21, g21, size21, addr21, b21, e21, at_end;
    logic [DW-1:0]   rs, re, rlen;
    logic            size_zero, full, scan_end;
    logic [IW-1:0]   idx_m1, idx_p1;

    assign lo21      = DW'(i_cfg.lo);
    assign hi21      = DW'(i_cfg.hi);
    assign g21       = DW'(i_cfg.g);
    assign size21    = DW'(r_size);
    assign addr21    = DW'(r_addr);
    assign b21       = DW'(i_mem_rdata.base);
    assign e21       = b21 + DW'(i_mem_rdata.len);
    assign at_end    = addr21 + size21;
    assign size_zero = (r_size == '0);
    assign full      = (r_cnt >= IW'(MAX_RANGES));
    assign idx_m1    = r_idx - IW'(1);
    assign idx_p1    = r_idx + IW'(1);
    assign scan_end  = (r_ph == PH_GAP_DN) ? (r_idx == '0) : (r_idx == r_cnt);

    // release span: whole range on zero size, else the requested pages
    assign rs   = size_zero ? b21 : addr21;
    assign re   = size_zero ? e21 : at_end;
    assign rlen = re - rs;

    // decide what this cycle does
    always_comb begin
        act   = ACT_WAIT;
        fcode = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) act = ACT_ACCEPT;
            end
            S_CHECK: begin
                case (r_mode)
                    MODE_ANY: begin
                        if (size_zero) begin
                            act = ACT_FAIL; fcode = ST_INVALID;
                        end else if (r_top && (size21 + lo21 > hi21)) begin
                            act = ACT_FAIL; fcode = ST_NO_SPACE;
                        end else if (r_top) begin
                            act = ACT_REM;
                        end else begin
                            act = ACT_SCAN;
                        end
                    end
                    MODE_AT: begin
                        if (size_zero || addr21 < lo21 || addr21 >= hi21 || at_end > hi21) begin
                            act = ACT_FAIL; fcode = ST_INVALID;
                        end else begin
                            act = ACT_REM;
                        end
                    end
                    default: begin
                        if (r_mode == MODE_QRY && addr21 >= hi21) begin
                            act = ACT_FAIL; fcode = ST_INVALID;
                        end else begin
                            act = ACT_SCAN;
                        end
                    end
                endcase
            end
            S_REM_WAIT: begin
                if (i_rem.done) act = ACT_REM_DONE;
            end
            S_RD: begin
                if (scan_end) begin
                    case (r_ph)
                        PH_GAP_UP: begin
                            if (r_cur + size21 > hi21) begin
                                act = ACT_FAIL; fcode = ST_NO_SPACE;
                            end else if (full) begin
                                act = ACT_FAIL; fcode = ST_TABLE_FULL;
                            end else begin
                                act = ACT_PLACE;
                            end
                        end
                        PH_GAP_DN: begin
                            if (r_cur < lo21) begin
                                act = ACT_FAIL; fcode = ST_NO_SPACE;
                            end else if (full) begin
                                act = ACT_FAIL; fcode = ST_TABLE_FULL;
                            end else begin
                                act = ACT_PLACE;
                            end
                        end
                        PH_AT: begin
                            if (full) begin
                                act = ACT_FAIL; fcode = ST_TABLE_FULL;
                            end else begin
                                act = ACT_PLACE;
                            end
                        end
                        PH_FIND: begin
                            if (r_mode == MODE_REL) begin
                                act = ACT_FAIL; fcode = ST_NOT_RESERVED;
                            end else begin
                                act = ACT_QRY_FREE;
                            end
                        end
                        default: act = ACT_POS_FOUND;
                    endcase
                end else begin
                    act = ACT_READ;
                end
            end
            S_EV: begin
                case (r_ph)
                    PH_GAP_UP: begin
                        if (b21 >= r_cur && (b21 - r_cur) >= size21) begin
                            if (full) begin
                                act = ACT_FAIL; fcode = ST_TABLE_FULL;
                            end else begin
                                act = ACT_PLACE;
                            end
                        end else if (e21 > r_cur) begin
                            act = ACT_REM;
                        end else begin
                            act = ACT_STEP;
                        end
                    end
                    PH_GAP_DN: begin
                        if (e21 <= r_cur) begin
                            if (r_cur < lo21) begin
                                act = ACT_FAIL; fcode = ST_NO_SPACE;
                            end else if (full) begin
                                act = ACT_FAIL; fcode = ST_TABLE_FULL;
                            end else begin
                                act = ACT_PLACE;
                            end
                        end else if (b21 < size21 + lo21) begin
                            act = ACT_FAIL; fcode = ST_NO_SPACE;
                        end else begin
                            act = ACT_REM;
                        end
                    end
                    PH_AT: begin
                        if (b21 >= r_end) begin
                            if (full) begin
                                act = ACT_FAIL; fcode = ST_TABLE_FULL;
                            end else begin
                                act = ACT_PLACE;
                            end
                        end else if (e21 > r_cur) begin
                            act = ACT_FAIL; fcode = ST_CONFLICT;
                        end else begin
                            act = ACT_STEP;
                        end
                    end
                    PH_FIND: begin
                        if (addr21 < b21) begin
                            if (r_mode == MODE_REL) begin
                                act = ACT_FAIL; fcode = ST_NOT_RESERVED;
                            end else begin
                                act = ACT_QRY_FREE;
                            end
                        end else if (addr21 < e21) begin
                            if (r_mode == MODE_QRY) begin
                                act = ACT_QRY_HIT;
                            end else if (size_zero && addr21 != b21) begin
                                act = ACT_FAIL; fcode = ST_NOT_AT_BASE;
                            end else if (!size_zero && re > e21) begin
                                act = ACT_FAIL; fcode = ST_BEYOND;
                            end else if (rs == b21 && re == e21) begin
                                act = ACT_REL_WHOLE;
                            end else if (rs == b21 || re == e21) begin
                                act = ACT_REL_EDGE;
                            end else if (full) begin
                                act = ACT_FAIL; fcode = ST_TABLE_FULL;
                            end else begin
                                act = ACT_REL_MID;
                            end
                        end else begin
                            act = ACT_STEP;
                        end
                    end
                    default: begin
                        if (b21 > DW'(r_new.base)) act = ACT_POS_FOUND;
                        else                       act = ACT_STEP;
                    end
                endcase
            end
            S_UP_RD: act = (r_idx > r_pos) ? ACT_UP_READ : ACT_UP_LAST;
            S_UP_WR: act = ACT_UP_WRITE;
            S_DN_RD: act = (idx_p1 < r_cnt) ? ACT_DN_READ : ACT_DN_LAST;
            S_DN_WR: act = ACT_DN_WRITE;
            S_DONE:  act = ACT_FINISH;
            default: act = ACT_WAIT;
        endcase
    end

    // next state
    always_comb begin
        unique case (act)
            ACT_ACCEPT:    n_state = S_CHECK;
            ACT_FAIL:      n_state = S_DONE;
            ACT_SCAN:      n_state = S_RD;
            ACT_REM:       n_state = S_REM_WAIT;
            ACT_REM_DONE:  n_state = S_RD;
            ACT_READ:      n_state = S_EV;
            ACT_STEP:      n_state = S_RD;
            ACT_PLACE:     n_state = S_RD;
            ACT_POS_FOUND: n_state = S_UP_RD;
            ACT_QRY_FREE:  n_state = S_DONE;
            ACT_QRY_HIT:   n_state = S_DONE;
            ACT_REL_WHOLE: n_state = S_DN_RD;
            ACT_REL_EDGE:  n_state = S_DONE;
            ACT_REL_MID:   n_state = S_UP_RD;
            ACT_UP_READ:   n_state = S_UP_WR;
            ACT_UP_WRITE:  n_state = S_UP_RD;
            ACT_UP_LAST:   n_state = S_DONE;
            ACT_DN_READ:   n_state = S_DN_WR;
            ACT_DN_WRITE:  n_state = S_DN_RD;
            ACT_DN_LAST:   n_state = S_DONE;
            ACT_FINISH:    n_state = S_IDLE;
            default:       n_state = r_state;
        endcase
    end

    // datapath and port outputs
    always_comb begin
        logic [DW-1:0] lim;
        n_ph    = r_ph;
        n_rr    = r_rr;
        n_mode  = r_mode;
        n_addr  = r_addr;
        n_size  = r_size;
        n_top   = r_top;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_pos   = r_pos;
        n_cur   = r_cur;
        n_end   = r_end;
        n_new   = r_new;
        n_total = r_total;
        n_res   = r_res;
        o_rem.start = 1'b0;
        o_rem.x     = '0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx[AW-1:0];
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = r_idx[AW-1:0];
        lim = (r_state == S_RD) ? hi21 : b21;

        case (act)
            ACT_ACCEPT: begin
                n_mode = i_cmd.mode;
                n_addr = i_cmd.address_page;
                n_size = i_cmd.size_pages;
                n_top  = i_cmd.top_down;
                n_new.prot = i_cmd.protect_code;
                n_new.len  = i_cmd.size_pages;
                n_res  = '0;
                case (i_cmd.mode)
                    MODE_ANY: n_ph = i_cmd.top_down ? PH_GAP_DN : PH_GAP_UP;
                    MODE_AT:  n_ph = PH_AT;
                    default:  n_ph = PH_FIND;
                endcase
            end
            ACT_FAIL: begin
                n_res.status = fcode;
            end
            ACT_SCAN: begin
                n_idx = '0;
                n_cur = lo21;
            end
            ACT_REM: begin
                o_rem.start = 1'b1;
                case (r_ph)
                    PH_GAP_UP: begin
                        o_rem.x = e21 + g21 - DW'(1);
                        n_rr    = RR_UP;
                    end
                    PH_GAP_DN: begin
                        if (r_state == S_CHECK) begin
                            o_rem.x = hi21 - size21;
                            n_rr    = RR_DN_INIT;
                            n_idx   = r_cnt;
                        end else begin
                            o_rem.x = b21 - size21;
                            n_rr    = RR_DN;
                        end
                    end
                    default: begin
                        o_rem.x = addr21;
                        n_rr    = RR_AT;
                        n_end   = at_end;
                    end
                endcase
            end
            ACT_REM_DONE: begin
                case (r_rr)
                    RR_UP: begin
                        n_cur = i_rem.down;
                        n_idx = idx_p1;
                    end
                    RR_DN_INIT: n_cur = i_rem.down;
                    RR_DN: begin
                        if (i_rem.down < r_cur) n_cur = i_rem.down;
                        n_idx = idx_m1;
                    end
                    default: begin
                        n_cur      = i_rem.down;
                        n_new.base = i_rem.down[PW-1:0];
                        n_new.len  = LW'(r_end - i_rem.down);
                        n_idx      = '0;
                    end
                endcase
            end
            ACT_READ: begin
                if (r_ph == PH_GAP_DN) o_mem_raddr = idx_m1[AW-1:0];
            end
            ACT_STEP: begin
                n_idx = (r_ph == PH_GAP_DN) ? idx_m1 : idx_p1;
            end
            ACT_PLACE: begin
                if (r_ph != PH_AT) begin
                    n_new.base = r_cur[PW-1:0];
                    n_new.len  = r_size;
                end
                n_res.base_page    = n_new.base;
                n_res.length_pages = n_new.len;
                n_total = r_total + n_new.len;
                n_ph    = PH_POS;
                n_idx   = '0;
            end
            ACT_POS_FOUND: begin
                n_pos = r_idx;
                n_idx = r_cnt;
            end
            ACT_QRY_FREE: begin
                n_res.base_page    = r_addr;
                n_res.length_pages = LW'(lim - addr21);
            end
            ACT_QRY_HIT: begin
                n_res.base_page     = i_mem_rdata.base;
                n_res.length_pages  = LW'(e21 - addr21);
                n_res.is_reserved   = 1'b1;
                n_res.range_protect = i_mem_rdata.prot;
            end
            ACT_REL_WHOLE: begin
                n_res.base_page    = rs[PW-1:0];
                n_res.length_pages = LW'(rlen);
                n_total = r_total - LW'(rlen);
            end
            ACT_REL_EDGE: begin
                n_res.base_page    = rs[PW-1:0];
                n_res.length_pages = LW'(rlen);
                n_total  = r_total - LW'(rlen);
                o_mem_we = 1'b1;
                if (rs == b21) begin
                    // trim head
                    o_mem_wdata.base = re[PW-1:0];
                    o_mem_wdata.len  = LW'(e21 - re);
                end else begin
                    o_mem_wdata.len  = LW'(rs - b21);
                end
            end
            ACT_REL_MID: begin
                n_res.base_page    = rs[PW-1:0];
                n_res.length_pages = LW'(rlen);
                n_total  = r_total - LW'(rlen);
                o_mem_we = 1'b1;
                o_mem_wdata.len = LW'(rs - b21);
                n_new.base = re[PW-1:0];
                n_new.len  = LW'(e21 - re);
                n_new.prot = i_mem_rdata.prot;
                n_pos = idx_p1;
                n_idx = r_cnt;
            end
            ACT_UP_READ: begin
                o_mem_raddr = idx_m1[AW-1:0];
            end
            ACT_UP_WRITE: begin
                o_mem_we = 1'b1;
                n_idx    = idx_m1;
            end
            ACT_UP_LAST: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_pos[AW-1:0];
                o_mem_wdata = r_new;
                n_cnt       = r_cnt + IW'(1);
            end
            ACT_DN_READ: begin
                o_mem_raddr = idx_p1[AW-1:0];
            end
            ACT_DN_WRITE: begin
                o_mem_we = 1'b1;
                n_idx    = idx_p1;
            end
            ACT_DN_LAST: begin
                n_cnt = r_cnt - IW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ph   <= n_ph;
        r_rr   <= n_rr;
        r_mode <= n_mode;
        r_addr <= n_addr;
        r_size <= n_size;
        r_top  <= n_top;
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_cur  <= n_cur;
        r_end  <= n_end;
        r_new  <= n_new;
        r_res  <= n_res;
    end

    always_comb begin
        o_busy   = (r_state != S_IDLE);
        o_valid  = (r_state == S_DONE);
        o_result = r_res;
        o_result.reserved_total = r_total;
    end

endmodule

// ===== hw/rtl/address_range_reservation_table.sv =====
// Top level of the address range reservation table: config registers and wiring.
// Depends on arrt_pkg, arrt_rem, arrt_mem and arrt_seq.
//
// Usage: raise start with a request on i_cmd while busy is low; the request is
// taken at that clock edge and busy stays high until the result is out. The
// result appears on o_result for exactly one cycle with o_valid high; the
// receiver cannot stall, so it must take it then. Config registers are
// written through i_cfg_we / i_cfg_idx / i_cfg_wdata, with no read-back; the
// user must write them only while the block is idle, which the block does not enforce.
// Each request scans the sorted table one entry at a time; granule rounding is
// done by the shared remainder unit (at most once per entry scanned for reserve
// anywhere, plus once up front when top-down; once for reserve at an address).
// A new range or a split shifts the entries above its place up by one; a new range
// first scans to find that place. A whole release shifts the entries above it down.
// The next request can be taken in the cycle after the result. The table holds
// up to MAX_RANGES ranges, 64 by default. Reset empties the table and restores
// the default window.
`timescale 1ns / 1ps

module address_range_reservation_table import arrt_pkg::*; #(
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_cmd,
    output logic              o_valid,
    output t_rsp              o_result,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_idx,
    input  logic [LW-1:0]     i_cfg_wdata
);

    localparam int AW = $clog2(MAX_RANGES);

    logic [PW-1:0] r_lowest;
    logic [LW-1:0] r_highest;
    logic [GW-1:0] r_granule;
    t_cfg          cfg;

    t_rem_req      rem_req;
    t_rem_rsp      rem_rsp;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_entry        mem_wdata, mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest  <= LOWEST_RST;
            r_highest <= HIGHEST_RST;
            r_granule <= GRANULE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOWEST:  r_lowest  <= i_cfg_wdata[PW-1:0];
                CFG_HIGHEST: r_highest <= i_cfg_wdata;
                CFG_GRANULE: r_granule <= i_cfg_wdata[GW-1:0];
                default: ;
            endcase
        end
    end

    // clamp the window top, treat a zero granule as one
    always_comb begin
        cfg.lo = r_lowest;
        cfg.hi = (r_highest > PAGE_LIMIT) ? PAGE_LIMIT : r_highest;
        cfg.g  = (r_granule == '0) ? GW'(1) : r_granule;
    end

    arrt_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .i_g     (cfg.g),
        .o_rsp   (rem_rsp)
    );

    arrt_mem #(
        .DEPTH (MAX_RANGES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    arrt_seq #(
        .MAX_RANGES (MAX_RANGES),
        .AW         (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_cmd),
        .i_cfg       (cfg),
        .o_busy      (busy),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .o_rem       (rem_req),
        .i_rem       (rem_rsp),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

endmodule

// ===== tb/sv/tb_address_range_reservation_table.sv =====
// Self-checking testbench for the address range reservation table.
// Depends on arrt_pkg and address_range_reservation_table; predicts every response in a
// scoreboard class and drives requests, window changes and random traffic.
`timescale 1ns / 1ps

module tb_address_range_reservation_table;
    import arrt_pkg::*;

    localparam int DEPTH = 64;

    class range_table_scoreboard;
        int unsigned lo_pg, hi_pg, gr;
        int unsigned bases[DEPTH];
        int unsigned lens[DEPTH];
        int unsigned prots[DEPTH];
        int unsigned count, total;
        t_rsp        expected_q[$];
        int          errors;
        int          checked;

        function void reset_state();
            lo_pg = 16; hi_pg = 524256; gr = 16;
            count = 0; total = 0;
            expected_q.delete();
        endfunction

        function void write_reg(t_cfg_idx idx, int unsigned val);
            case (idx)
                CFG_LOWEST:  lo_pg = val & 32'h7FFFF;
                CFG_HIGHEST: hi_pg = val & 32'hFFFFF;
                CFG_GRANULE: gr    = val & 32'h1FF;
                default: ;
            endcase
        endfunction

        function int unsigned top_pg();
            return hi_pg > 524288 ? 524288 : hi_pg;
        endfunction

        function int unsigned floor_to_granule(int unsigned x);
            int unsigned g;
            g = gr == 0 ? 1 : gr;
            return x - x % g;
        endfunction

        function int unsigned ceil_to_granule(int unsigned x);
            int unsigned g;
            g = gr == 0 ? 1 : gr;
            return floor_to_granule(x + g - 1);
        endfunction

        function void insert_at(int unsigned pos, int unsigned b, int unsigned l,
                                int unsigned p);
            for (int unsigned i = count; i > pos; i--) begin
                bases[i] = bases[i-1]; lens[i] = lens[i-1]; prots[i] = prots[i-1];
            end
            bases[pos] = b; lens[pos] = l; prots[pos] = p;
            count++;
        endfunction

        function void remove_at(int unsigned pos);
            for (int unsigned i = pos; i + 1 < count; i++) begin
                bases[i] = bases[i+1]; lens[i] = lens[i+1]; prots[i] = prots[i+1];
            end
            count--;
        endfunction

        function int unsigned sorted_pos(int unsigned b);
            int unsigned i;
            for (i = 0; i < count; i++)
                if (bases[i] > b) break;
            return i;
        endfunction

        function int unsigned containing(int unsigned p);
            for (int unsigned i = 0; i < count; i++) begin
                if (p < bases[i]) break;
                if (p < bases[i] + lens[i]) return i;
            end
            return count;
        endfunction

        function bit first_fit(int unsigned size, bit top, output int unsigned where);
            int unsigned cur, b, e, c, hi;
            hi = top_pg();
            where = 0;
            if (!top) begin
                cur = lo_pg;
                for (int unsigned i = 0; i < count; i++) begin
                    b = bases[i]; e = b + lens[i];
                    if (b >= cur && b - cur >= size) begin
                        where = cur;
                        return 1;
                    end
                    if (e > cur) cur = ceil_to_granule(e);
                end
                if (cur + size <= hi) begin
                    where = cur;
                    return 1;
                end
                return 0;
            end
            if (size + lo_pg > hi) return 0;
            cur = floor_to_granule(hi - size);
            for (int unsigned i = count; i > 0; i--) begin
                b = bases[i-1]; e = b + lens[i-1];
                if (e <= cur) break;
                if (b < size + lo_pg) return 0;
                c = floor_to_granule(b - size);
                if (c < cur) cur = c;
            end
            if (cur < lo_pg) return 0;
            where = cur;
            return 1;
        endfunction

        function t_status reserve_any(int unsigned size, bit top, int unsigned p,
                                      output int unsigned ob, output int unsigned ol);
            int unsigned s;
            ob = 0; ol = 0;
            if (size == 0) return ST_INVALID;
            if (!first_fit(size, top, s)) return ST_NO_SPACE;
            if (count >= DEPTH) return ST_TABLE_FULL;
            insert_at(sorted_pos(s), s, size, p);
            total += size;
            ob = s; ol = size;
            return ST_OK;
        endfunction

        function t_status reserve_at(int unsigned a, int unsigned size, int unsigned p,
                                     output int unsigned ob, output int unsigned ol);
            int unsigned s, e;
            ob = 0; ol = 0;
            if (size == 0) return ST_INVALID;
            if (a < lo_pg || a >= top_pg()) return ST_INVALID;
            s = floor_to_granule(a);
            e = a + size;
            if (e > top_pg()) return ST_INVALID;
            for (int unsigned i = 0; i < count; i++) begin
                if (bases[i] >= e) break;
                if (bases[i] + lens[i] > s) return ST_CONFLICT;
            end
            if (count >= DEPTH) return ST_TABLE_FULL;
            insert_at(sorted_pos(s), s, e - s, p);
            total += e - s;
            ob = s; ol = e - s;
            return ST_OK;
        endfunction

        function t_status release_pages(int unsigned a, int unsigned size,
                                        output int unsigned ob, output int unsigned ol);
            int unsigned k, b, e, s, f;
            ob = 0; ol = 0;
            k = containing(a);
            if (k >= count) return ST_NOT_RESERVED;
            b = bases[k]; e = b + lens[k];
            if (size == 0) begin
                if (a != b) return ST_NOT_AT_BASE;
                s = b; f = e;
            end else begin
                s = a; f = a + size;
                if (f > e) return ST_BEYOND;
            end
            if (s == b && f == e) begin
                remove_at(k);
            end else if (s == b) begin
                bases[k] = f; lens[k] = e - f;
            end else if (f == e) begin
                lens[k] = s - b;
            end else begin
                if (count >= DEPTH) return ST_TABLE_FULL;
                lens[k] = s - b;
                insert_at(k + 1, f, e - f, prots[k]);
            end
            total -= f - s;
            ob = s; ol = f - s;
            return ST_OK;
        endfunction

        // Predict the response of one accepted request and queue it.
        function void note_request(t_req r);
            t_rsp        x;
            int unsigned ob, ol, isr, rp, k, lim;
            t_status     st;
            ob = 0; ol = 0; isr = 0; rp = 0;
            case (r.mode)
                MODE_ANY: st = reserve_any(r.size_pages, r.top_down, r.protect_code, ob, ol);
                MODE_AT:  st = reserve_at(r.address_page, r.size_pages, r.protect_code, ob, ol);
                MODE_REL: st = release_pages(r.address_page, r.size_pages, ob, ol);
                default: begin
                    if (r.address_page >= top_pg()) begin
                        st = ST_INVALID;
                    end else begin
                        st = ST_OK;
                        k = containing(r.address_page);
                        if (k < count) begin
                            ob = bases[k];
                            ol = bases[k] + lens[k] - r.address_page;
                            isr = 1;
                            rp = prots[k];
                        end else begin
                            lim = top_pg();
                            for (int unsigned i = 0; i < count; i++)
                                if (bases[i] > r.address_page) begin
                                    lim = bases[i];
                                    break;
                                end
                            ob = r.address_page;
                            ol = lim - r.address_page;
                        end
                    end
                end
            endcase
            x.status         = st;
            x.base_page      = ob[PW-1:0];
            x.length_pages   = ol[LW-1:0];
            x.is_reserved    = isr[0];
            x.range_protect  = rp[CW-1:0];
            x.reserved_total = total[LW-1:0];
            expected_q.push_back(x);
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            $display("ERROR t=%0t response %0d: %s got %0d, want %0d",
                     $time, checked, what, got, want);
            errors++;
        endtask

        task check_result(t_rsp got);
            t_rsp want;
            if (expected_q.size() == 0) begin
                report("unexpected response, status", got.status, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.status != want.status)
                report("status", got.status, want.status);
            if (got.base_page != want.base_page)
                report("base_page", got.base_page, want.base_page);
            if (got.length_pages != want.length_pages)
                report("length_pages", got.length_pages, want.length_pages);
            if (got.is_reserved != want.is_reserved)
                report("is_reserved", got.is_reserved, want.is_reserved);
            if (got.range_protect != want.range_protect)
                report("range_protect", got.range_protect, want.range_protect);
            if (got.reserved_total != want.reserved_total)
                report("reserved_total", got.reserved_total, want.reserved_total);
            checked++;
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_req              i_cmd;
    logic              o_valid;
    t_rsp              o_result;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_idx;
    logic [LW-1:0]     i_cfg_wdata;

    range_table_scoreboard sb;
    int                    accepted;
    int                    burst_left;
    bit                    gaps_on;

    address_range_reservation_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_result);
    end

    function automatic t_req mk(t_mode m, int unsigned a, int unsigned s, bit top,
                                int unsigned p);
        t_req r;
        r.mode = m;
        r.address_page = a[PW-1:0];
        r.size_pages = s[LW-1:0];
        r.top_down = top;
        r.protect_code = p[CW-1:0];
        return r;
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send(t_req r);
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(r);
        accepted++;
        if (--burst_left <= 0) begin
            burst_left = $urandom_range(1, 10);
            if (gaps_on) begin
                @(negedge i_clk);
                start <= 1'b0;
                repeat ($urandom_range(0, 25)) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.expected_q.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val[LW-1:0];
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_window(int unsigned lo, int unsigned hi, int unsigned g);
        drain();
        write_reg(CFG_LOWEST, lo);
        write_reg(CFG_HIGHEST, hi);
        write_reg(CFG_GRANULE, g);
    endtask

    function automatic int unsigned pick_size();
        int unsigned c;
        c = $urandom_range(0, 99);
        if (c < 3) return 0;
        if (c < 8) return $urandom_range(0, 20'hFFFFF);
        if (c < 20) return $urandom_range(1, 400);
        return $urandom_range(1, 40);
    endfunction

    function automatic int unsigned pick_addr();
        int unsigned hi;
        hi = sb.top_pg();
        if ($urandom_range(0, 9) == 0 || hi <= sb.lo_pg) return $urandom_range(0, 20'h7FFFF);
        return sb.lo_pg + $urandom % (hi - sb.lo_pg);
    endfunction

    // Mostly well-formed traffic aimed at existing ranges, with some noise.
    function automatic t_req random_request();
        int unsigned c, k, b, l, off, s;
        bit          top;
        int unsigned p;
        top = $urandom_range(0, 1);
        p = $urandom_range(0, 2047);
        c = $urandom_range(0, 99);
        if (c < 35) return mk(MODE_ANY, $urandom_range(0, 20'h7FFFF), pick_size(), top, p);
        if (c < 50) return mk(MODE_AT, pick_addr(), pick_size(), top, p);
        if (sb.count == 0 || $urandom_range(0, 9) == 0) begin
            if (c < 80) return mk(MODE_REL, pick_addr(), pick_size(), top, p);
            return mk(MODE_QRY, pick_addr(), pick_size(), top, p);
        end
        k = $urandom_range(0, sb.count - 1);
        b = sb.bases[k];
        l = sb.lens[k];
        if (c >= 80) return mk(MODE_QRY, b + $urandom_range(0, l), pick_size(), top, p);
        case ($urandom_range(0, 5))
            0: return mk(MODE_REL, b, 0, top, p);
            1: return mk(MODE_REL, b, $urandom_range(1, l), top, p);
            2: begin
                s = $urandom_range(1, l);
                return mk(MODE_REL, b + l - s, s, top, p);
            end
            3: begin
                if (l < 3) return mk(MODE_REL, b, 0, top, p);
                off = $urandom_range(1, l - 2);
                return mk(MODE_REL, b + off, $urandom_range(1, l - 1 - off), top, p);
            end
            4: return mk(MODE_REL, b + $urandom_range(0, l - 1), l + $urandom_range(1, 8),
                         top, p);
            default: begin
                if (l < 2) return mk(MODE_REL, b, 0, top, p);
                return mk(MODE_REL, b + $urandom_range(1, l - 1), 0, top, p);
            end
        endcase
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 60 == 0) gaps_on = $urandom_range(0, 2) != 0;
            send(random_request());
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        sb.errors = 0;
        sb.checked = 0;
        accepted = 0;
        burst_left = 1;
        gaps_on = 1'b1;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests on the reset window
        send(mk(MODE_ANY, 0, 0, 0, 0));
        send(mk(MODE_ANY, 0, 1, 0, 1));
        send(mk(MODE_ANY, 20'h7FFFF, 100, 1, 2047));
        send(mk(MODE_ANY, 0, 20'hFFFFF, 0, 3));
        send(mk(MODE_AT, 0, 10, 0, 4));
        send(mk(MODE_AT, 524287, 10, 0, 5));
        send(mk(MODE_AT, 524250, 100, 0, 6));
        send(mk(MODE_AT, 1000, 500, 1, 11'h555));
        send(mk(MODE_AT, 1100, 4, 0, 7));
        send(mk(MODE_QRY, 1200, 0, 0, 0));
        send(mk(MODE_QRY, 5000, 0, 0, 0));
        send(mk(MODE_QRY, 524287, 0, 0, 0));
        send(mk(MODE_REL, 3000, 0, 0, 0));
        send(mk(MODE_REL, 1100, 0, 0, 0));
        send(mk(MODE_REL, 1400, 200, 0, 0));
        send(mk(MODE_REL, 992, 8, 0, 0));
        send(mk(MODE_REL, 1490, 10, 0, 0));
        send(mk(MODE_REL, 1200, 50, 0, 0));
        send(mk(MODE_QRY, 1260, 0, 0, 0));
        send(mk(MODE_REL, 1000, 0, 0, 0));
        send(mk(MODE_QRY, 16, 0, 0, 0));
        send(mk(MODE_AT, 20'h2AAAA, 0, 0, 11'h2AA));

        random_phase(150);
        set_window(0, 4096, 1);
        random_phase(150);
        set_window(524287, 20'hFFFFF, 256);
        random_phase(40);
        set_window(100, 3000, 0);
        random_phase(100);
        set_window(37, 5000, 3);
        random_phase(100);
        set_window(0, 1, 255);
        random_phase(30);
        set_window(0, 20000, 16);
        random_phase(100);
        // shrink the window under existing ranges
        set_window(0, 8000, 64);
        random_phase(100);

        drain();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d requests and %0d responses over eight window settings,",
                 accepted, sb.checked);
        $display("including reserves, trims, splits, whole releases and queries.");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timeout with %0d responses outstanding", sb.expected_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/arrt_pkg.sv
hw/rtl/arrt_rem.sv
hw/rtl/arrt_mem.sv
hw/rtl/arrt_seq.sv
hw/rtl/address_range_reservation_table.sv
tb/sv/tb_address_range_reservation_table.sv
